>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant violated");

// check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication violated");

// check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

>>> sv/srrw_pkg.sv
package srrw_pkg;

   localparam int SEQ_BITS  = 8;
   localparam int SEQ_SPACE = 256;
   localparam int LEN_BITS  = 10;
   localparam int FREE_BITS = 4;
   localparam int KIND_BITS = 2;

   localparam logic [KIND_BITS-1:0] KIND_DELIVER = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_ACK     = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_OUTSIDE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_OOW,
      ST_READ,
      ST_DLV,
      ST_ACK
   } state_type;

endpackage

>>> sv/srrw_slot_ram.sv
module srrw_slot_ram #(
   parameter int DEPTH     = 8,
   parameter int DATA_BITS = 26
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_BITS-1:0]     wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_BITS-1:0]     rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/selective_repeat_receive_window_core.sv
// Throughput: a new header is taken only after the previous one is fully handled (sequential).
// An ignored or silently buffered header passes ST_EVAL only; an out-of-window header passes
// ST_EVAL and ST_OOW, which loads its result. An in-order header passes ST_EVAL, then ST_READ
// and ST_DLV per delivered packet, then ST_READ and ST_ACK; a zero-length delivery goes to
// ST_ACK at once. A stalled result holds the state. Reset (synchronous, active high) clears
// valid bits, counters, session flags, strict_start and result valid; slot memory is not cleared.
module selective_repeat_receive_window_core #(
   parameter int WINDOW      = 8,
   parameter int MAX_PAYLOAD = 512,
   parameter int TAG_BITS    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic                               csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_decode_ok,
   input  logic                               req_is_data,
   input  logic [srrw_pkg::SEQ_BITS-1:0]      req_seq_number,
   input  logic [srrw_pkg::LEN_BITS-1:0]      req_payload_length,
   input  logic [TAG_BITS-1:0]                req_payload_tag,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [srrw_pkg::KIND_BITS-1:0]     rsp_result_kind,
   output logic [srrw_pkg::SEQ_BITS-1:0]      rsp_out_seq,
   output logic [srrw_pkg::LEN_BITS-1:0]      rsp_out_length,
   output logic [TAG_BITS-1:0]                rsp_out_tag,
   output logic [srrw_pkg::FREE_BITS-1:0]     rsp_free_slots,
   output logic                               rsp_last_of_run,
   output logic                               rsp_session_over
);

   import srrw_pkg::*;

   `include "assert_macros.svh"

   localparam int SW        = $clog2(WINDOW);
   localparam int CW        = $clog2(WINDOW + 1);
   localparam int DATA_BITS = TAG_BITS + LEN_BITS;
   localparam logic [CW-1:0]       WIN_C   = CW'(WINDOW);
   localparam logic [SEQ_BITS-1:0] WIN_SEQ = SEQ_BITS'(WINDOW);
   localparam logic [16:0]         MAX_LEN = 17'(MAX_PAYLOAD);

   function automatic logic [SEQ_SPACE*SW-1:0] build_slot_lut();
      logic [SEQ_SPACE*SW-1:0] lut;
      lut = '0;
      for (int i = 0; i < SEQ_SPACE; i++) begin
         lut[i*SW +: SW] = SW'(i % WINDOW);
      end
      return lut;
   endfunction

   localparam logic [SEQ_SPACE*SW-1:0] SLOT_LUT = build_slot_lut();

   state_type state_ff, state_in;

   logic                 strict_ff;
   logic                 started_ff, started_in;
   logic                 finished_ff, finished_in;
   logic [SEQ_BITS-1:0]  expected_ff, expected_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [WINDOW-1:0]    valid_ff, valid_in;

   logic                 ok_ff, data_ff;
   logic [SEQ_BITS-1:0]  seq_ff;
   logic [LEN_BITS-1:0]  len_ff;
   logic [TAG_BITS-1:0]  tag_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0] kind_ff, kind_in;
   logic [SEQ_BITS-1:0]  oseq_ff, oseq_in;
   logic [LEN_BITS-1:0]  olen_ff, olen_in;
   logic [TAG_BITS-1:0]  otag_ff, otag_in;
   logic [FREE_BITS-1:0] ofree_ff, ofree_in;
   logic                 olast_ff, olast_in;
   logic                 oover_ff, oover_in;

   logic                 req_take;
   logic                 out_ready;
   logic                 out_load;
   logic                 ignore;
   logic                 start_fail;
   logic [SEQ_BITS-1:0]  exp_eff;
   logic [SEQ_BITS-1:0]  seq_gap;
   logic                 outside;
   logic [SW-1:0]        in_slot;
   logic [SW-1:0]        drain_slot;
   logic                 drain_hit;
   logic [CW-1:0]        cnt_dec;

   logic                 wr_en;
   logic                 rd_en;
   logic [DATA_BITS-1:0] rd_data;
   logic [LEN_BITS-1:0]  rd_len;
   logic [TAG_BITS-1:0]  rd_tag;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign out_ready  = !rsp_valid_ff || !rsp_stall;

   assign ignore     = finished_ff || !ok_ff || !data_ff || ({7'd0, len_ff} > MAX_LEN);
   assign start_fail = !started_ff && strict_ff && (seq_ff != '0);
   assign exp_eff    = started_ff ? expected_ff : seq_ff;
   assign seq_gap    = seq_ff - exp_eff;
   assign outside    = (seq_gap >= WIN_SEQ);
   assign in_slot    = SLOT_LUT[int'(seq_ff)*SW +: SW];
   assign drain_slot = SLOT_LUT[int'(expected_ff)*SW +: SW];
   assign drain_hit  = valid_ff[drain_slot];
   assign cnt_dec    = (cnt_ff != '0) ? cnt_ff - CW'(1) : cnt_ff;

   assign rd_len     = rd_data[LEN_BITS-1:0];
   assign rd_tag     = rd_data[DATA_BITS-1:LEN_BITS];

   assign wr_en      = (state_ff == ST_EVAL) && !ignore && !start_fail && !outside;
   assign rd_en      = (state_ff == ST_READ) && drain_hit;

   srrw_slot_ram #(
      .DEPTH     (WINDOW),
      .DATA_BITS (DATA_BITS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (in_slot),
      .wr_data ({tag_ff, len_ff}),
      .rd_en   (rd_en),
      .rd_addr (drain_slot),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (ignore || start_fail) begin
               state_in = ST_IDLE;
            end else if (outside) begin
               state_in = ST_OOW;
            end else if (seq_gap != '0) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_OOW: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = drain_hit ? ST_DLV : ST_ACK;
         end
         ST_DLV: begin
            if (out_ready) begin
               state_in = (rd_len == '0) ? ST_ACK : ST_READ;
            end
         end
         ST_ACK: begin
            if (out_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      started_in  = started_ff;
      finished_in = finished_ff;
      expected_in = expected_ff;
      cnt_in      = cnt_ff;
      valid_in    = valid_ff;
      out_load    = 1'b0;
      kind_in     = kind_ff;
      oseq_in     = oseq_ff;
      olen_in     = olen_ff;
      otag_in     = otag_ff;
      ofree_in    = ofree_ff;
      olast_in    = olast_ff;
      oover_in    = oover_ff;
      case (state_ff)
         ST_EVAL: begin
            if (!ignore) begin
               if (start_fail) begin
                  finished_in = 1'b1;
               end else begin
                  started_in  = 1'b1;
                  expected_in = exp_eff;
                  if (!outside) begin
                     valid_in[in_slot] = 1'b1;
                     if (!valid_ff[in_slot]) begin
                        cnt_in = cnt_ff + CW'(1);
                     end
                  end
               end
            end
         end
         ST_OOW: begin
            if (out_ready) begin
               out_load = 1'b1;
               kind_in  = KIND_OUTSIDE;
               oseq_in  = seq_ff;
               olen_in  = '0;
               otag_in  = '0;
               ofree_in = FREE_BITS'(WIN_C - cnt_ff);
               olast_in = 1'b1;
               oover_in = finished_ff;
            end
         end
         ST_DLV: begin
            if (out_ready) begin
               out_load               = 1'b1;
               valid_in[drain_slot]   = 1'b0;
               cnt_in                 = cnt_dec;
               expected_in            = expected_ff + SEQ_BITS'(1);
               finished_in            = finished_ff || (rd_len == '0);
               kind_in                = KIND_DELIVER;
               oseq_in                = expected_ff;
               olen_in                = rd_len;
               otag_in                = rd_tag;
               ofree_in               = FREE_BITS'(WIN_C - cnt_dec);
               olast_in               = 1'b0;
               oover_in               = finished_ff || (rd_len == '0);
            end
         end
         ST_ACK: begin
            if (out_ready) begin
               out_load = 1'b1;
               kind_in  = KIND_ACK;
               oseq_in  = expected_ff;
               olen_in  = '0;
               otag_in  = '0;
               ofree_in = FREE_BITS'(WIN_C - cnt_ff);
               olast_in = 1'b1;
               oover_in = finished_ff;
            end
         end
         default: begin
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         strict_ff    <= 1'b0;
         started_ff   <= 1'b0;
         finished_ff  <= 1'b0;
         expected_ff  <= '0;
         cnt_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         finished_ff  <= finished_in;
         expected_ff  <= expected_in;
         cnt_ff       <= cnt_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            strict_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         ok_ff   <= req_decode_ok;
         data_ff <= req_is_data;
         seq_ff  <= req_seq_number;
         len_ff  <= req_payload_length;
         tag_ff  <= req_payload_tag;
      end
      kind_ff  <= kind_in;
      oseq_ff  <= oseq_in;
      olen_ff  <= olen_in;
      otag_ff  <= otag_in;
      ofree_ff <= ofree_in;
      olast_ff <= olast_in;
      oover_ff <= oover_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_out_seq      = oseq_ff;
   assign rsp_out_length   = olen_ff;
   assign rsp_out_tag      = otag_ff;
   assign rsp_free_slots   = ofree_ff;
   assign rsp_last_of_run  = olast_ff;
   assign rsp_session_over = oover_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, cnt_ff <= WIN_C)
   `ASSERT_ALWAYS(a_count_matches_valid, clock, reset, $countones(valid_ff) == int'(cnt_ff))
   `ASSERT_NEXT(a_finished_sticky, clock, reset, finished_ff, finished_ff)
   `ASSERT_IMPLIES(a_drain_slot_valid, clock, reset, state_ff == ST_DLV, valid_ff[drain_slot])

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import srrw_pkg::*;

   localparam int WIN         = 8;
   localparam int MAX_LEN     = 512;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 32;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [SEQ_BITS-1:0]  seq;
      logic [LEN_BITS-1:0]  len;
      logic [15:0]          tag;
      logic [FREE_BITS-1:0] free;
      logic                 last;
      logic                 over;
   } window_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic                  csr_write_data = 1'b0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_decode_ok = 1'b0;
   logic                  req_is_data = 1'b0;
   logic [SEQ_BITS-1:0]   req_seq_number = '0;
   logic [LEN_BITS-1:0]   req_payload_length = '0;
   logic [15:0]           req_payload_tag = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_BITS-1:0]  rsp_result_kind;
   logic [SEQ_BITS-1:0]   rsp_out_seq;
   logic [LEN_BITS-1:0]   rsp_out_length;
   logic [15:0]           rsp_out_tag;
   logic [FREE_BITS-1:0]  rsp_free_slots;
   logic                  rsp_last_of_run;
   logic                  rsp_session_over;

   // window state mirrored by the testbench
   bit                    win_valid [WIN];
   logic [15:0]           win_tag [WIN];
   logic [LEN_BITS-1:0]   win_len [WIN];
   bit [SEQ_BITS-1:0]     next_seq;
   int                    held;
   bit                    sess_started;
   bit                    sess_done;
   bit                    start_strict;
   bit                    strict_mode;

   window_result_type     due_results [$];
   int                    mismatches;
   int                    cycles;
   int                    req_idle_pct = 30;
   int                    rsp_idle_pct = 30;
   int                    stall_left;
   int                    hold_left;
   int                    hold_reqs;
   int                    hold_seen;

   selective_repeat_receive_window_core #(
      .WINDOW      (WIN),
      .MAX_PAYLOAD (MAX_LEN),
      .TAG_BITS    (16)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_decode_ok      (req_decode_ok),
      .req_is_data        (req_is_data),
      .req_seq_number     (req_seq_number),
      .req_payload_length (req_payload_length),
      .req_payload_tag    (req_payload_tag),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_out_seq        (rsp_out_seq),
      .rsp_out_length     (rsp_out_length),
      .rsp_out_tag        (rsp_out_tag),
      .rsp_free_slots     (rsp_free_slots),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_session_over   (rsp_session_over)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int pick_gap();
      if ($urandom_range(9) == 0)
         return $urandom_range(12, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic void owe(input logic [KIND_BITS-1:0] kind,
                               input logic [SEQ_BITS-1:0] seq,
                               input logic [LEN_BITS-1:0] len, input logic [15:0] tag,
                               input logic last);
      window_result_type r;
      r.kind = kind;
      r.seq  = seq;
      r.len  = len;
      r.tag  = tag;
      r.free = FREE_BITS'(WIN - held);
      r.last = last;
      r.over = sess_done;
      due_results.push_back(r);
   endfunction

   function automatic void advance_window(input logic ok, input logic data,
                                          input logic [SEQ_BITS-1:0] seq,
                                          input logic [LEN_BITS-1:0] len,
                                          input logic [15:0] tag);
      logic [SEQ_BITS-1:0] ahead;
      logic [LEN_BITS-1:0] dl;
      int                  s;
      if (sess_done || !ok || !data || len > 10'(MAX_LEN))
         return;
      if (!sess_started) begin
         if (start_strict && seq != 8'd0) begin
            sess_done = 1'b1;
            return;
         end
         sess_started = 1'b1;
         next_seq = seq;
      end
      ahead = seq - next_seq;
      if (ahead >= 8'(WIN)) begin
         owe(KIND_OUTSIDE, seq, '0, '0, 1'b1);
         return;
      end
      s = seq % WIN;
      if (!win_valid[s])
         held++;
      win_valid[s] = 1'b1;
      win_tag[s] = tag;
      win_len[s] = len;
      if (ahead != '0)
         return;
      while (win_valid[next_seq % WIN]) begin
         s = next_seq % WIN;
         dl = win_len[s];
         win_valid[s] = 1'b0;
         if (held > 0)
            held--;
         if (dl == '0)
            sess_done = 1'b1;
         owe(KIND_DELIVER, next_seq, dl, win_tag[s], 1'b0);
         next_seq++;
         if (sess_done)
            break;
      end
      owe(KIND_ACK, next_seq, '0, '0, 1'b1);
   endfunction

   task automatic send_packet(input logic ok, input logic data, input logic [SEQ_BITS-1:0] seq,
                              input logic [LEN_BITS-1:0] len, input logic [15:0] tag);
      int gap;
      gap = ($urandom_range(99) < req_idle_pct) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_decode_ok      <= ok;
      req_is_data        <= data;
      req_seq_number     <= seq;
      req_payload_length <= len;
      req_payload_tag    <= tag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_window(ok, data, seq, len, tag);
   endtask

   // drop valid, drain all results, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_strict(input bit value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      start_strict = value;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_reqs != hold_seen) begin
         hold_seen = hold_reqs;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(99) < rsp_idle_pct) begin
         stall_left = pick_gap() - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic report(input string what, input window_result_type want,
                         input window_result_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s at cycle %0d", what, cycles);
         $display("  expected kind=%0d seq=%0d len=%0d tag=%h free=%0d last=%b over=%b",
                  want.kind, want.seq, want.len, want.tag, want.free, want.last, want.over);
         $display("  actual   kind=%0d seq=%0d len=%0d tag=%h free=%0d last=%b over=%b",
                  got.kind, got.seq, got.len, got.tag, got.free, got.last, got.over);
      end
   endtask

   always @(posedge clock) begin : check_results
      window_result_type got;
      window_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_result_kind, rsp_out_seq, rsp_out_length, rsp_out_tag, rsp_free_slots,
                rsp_last_of_run, rsp_session_over};
         if (due_results.size() == 0) begin
            report("unexpected transaction", '0, got);
         end else begin
            want = due_results.pop_front();
            if (got.kind !== want.kind || got.seq !== want.seq || got.len !== want.len ||
                got.tag !== want.tag || got.free !== want.free || got.last !== want.last ||
                got.over !== want.over)
               report("mismatch", want, got);
         end
      end
   end

   task automatic test_before_start();
      send_packet(1'b0, 1'b1, 8'($urandom_range(1, 255)), 10'd100, 16'($urandom));
      send_packet(1'b1, 1'b0, 8'($urandom_range(1, 255)), 10'd0, 16'($urandom));
      send_packet(1'b1, 1'b1, 8'($urandom_range(1, 255)), 10'd1023, 16'($urandom));
      wait_idle();
   endtask

   task automatic test_start_rule();
      logic [SEQ_BITS-1:0] first;
      write_strict(!strict_mode);
      write_strict(strict_mode);
      first = strict_mode ? 8'd0 : 8'($urandom_range(200, 255));
      send_packet(1'b1, 1'b1, first, 10'd512, 16'hFFFF);
      wait_idle();
   endtask

   task automatic test_window_edges();
      logic [SEQ_BITS-1:0] e;
      e = next_seq;
      send_packet(1'b1, 1'b1, e + 8'd7, 10'd1, 16'h0000);
      send_packet(1'b1, 1'b1, e + 8'd1, 10'd300, 16'($urandom));
      send_packet(1'b1, 1'b1, e + 8'd1, 10'd511, 16'hA5A5);
      send_packet(1'b1, 1'b1, e + 8'd8, 10'd100, 16'h1234);
      send_packet(1'b1, 1'b1, e - 8'd1, 10'd200, 16'($urandom));
      send_packet(1'b1, 1'b1, e, 10'd513, 16'($urandom));
      send_packet(1'b1, 1'b0, e, 10'd50, 16'($urandom));
      send_packet(1'b0, 1'b1, e, 10'd50, 16'($urandom));
      send_packet(1'b1, 1'b1, e, 10'd64, 16'($urandom));
      wait_idle();
   endtask

   task automatic test_full_drain();
      logic [SEQ_BITS-1:0] e;
      e = next_seq;
      for (int d = WIN - 1; d >= 0; d--)
         send_packet(1'b1, 1'b1, e + 8'(d), 10'($urandom_range(1, MAX_LEN)), 16'($urandom));
      wait_idle();
   endtask

   task automatic test_back_pressure();
      logic [SEQ_BITS-1:0] e;
      req_idle_pct = 0;
      hold_reqs++;
      e = next_seq;
      for (int d = WIN - 1; d >= 0; d--)
         send_packet(1'b1, 1'b1, e + 8'(d), 10'($urandom_range(1, MAX_LEN)), 16'($urandom));
      repeat (4) send_packet(1'b1, 1'b1, next_seq, 10'($urandom_range(1, MAX_LEN)),
                             16'($urandom));
      repeat (2) send_packet(1'b1, 1'b1, next_seq + 8'($urandom_range(WIN, 255)),
                             10'($urandom_range(0, MAX_LEN)), 16'($urandom));
      wait_idle();
   endtask

   task automatic test_random_traffic(input int count, input int req_pct, input int rsp_pct,
                                      input bit strict_after);
      int                  sent;
      int                  pick;
      int                  k;
      int                  j;
      int                  t;
      int                  offs [WIN];
      logic [SEQ_BITS-1:0] base;
      logic                ok;
      logic                data;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            // shuffled run of consecutive packets starting at the expected number
            k = $urandom_range(1, WIN);
            base = next_seq;
            for (int i = 0; i < k; i++)
               offs[i] = i;
            for (int i = k - 1; i > 0; i--) begin
               j = $urandom_range(i);
               t = offs[i];
               offs[i] = offs[j];
               offs[j] = t;
            end
            for (int i = 0; i < k; i++) begin
               send_packet(1'b1, 1'b1, base + 8'(offs[i]), 10'($urandom_range(1, MAX_LEN)),
                           16'($urandom));
               sent++;
               if ($urandom_range(99) < 15) begin
                  send_packet(1'b1, 1'b1, base + 8'(offs[i]), 10'($urandom_range(1, MAX_LEN)),
                              16'($urandom));
                  sent++;
               end
            end
         end else if (pick < 72) begin
            send_packet(1'b1, 1'b1, next_seq + 8'($urandom_range(1, WIN - 1)),
                        10'($urandom_range(1, MAX_LEN)), 16'($urandom));
            sent++;
         end else if (pick < 84) begin
            send_packet(1'b1, 1'b1, next_seq + 8'($urandom_range(WIN, 255)),
                        10'($urandom_range(0, MAX_LEN)), 16'($urandom));
            sent++;
         end else begin
            ok = 1'($urandom_range(1));
            data = 1'($urandom_range(1));
            if (ok && data)
               send_packet(1'b1, 1'b1, 8'($urandom), 10'($urandom_range(MAX_LEN + 1, 1023)),
                           16'($urandom));
            else
               send_packet(ok, data, 8'($urandom), 10'($urandom_range(0, 1023)),
                           16'($urandom));
            sent++;
         end
      end
      wait_idle();
      write_strict(strict_after);
   endtask

   task automatic test_session_end();
      logic [SEQ_BITS-1:0] e;
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      e = next_seq;
      send_packet(1'b1, 1'b1, e + 8'd2, 10'd0, 16'($urandom));
      send_packet(1'b1, 1'b1, e + 8'd3, 10'd5, 16'($urandom));
      send_packet(1'b1, 1'b1, e + 8'd1, 10'd7, 16'($urandom));
      send_packet(1'b1, 1'b1, e, 10'd9, 16'($urandom));
      // everything after the final delivery is dropped
      send_packet(1'b1, 1'b1, next_seq, 10'd10, 16'($urandom));
      send_packet(1'b1, 1'b1, next_seq + 8'd100, 10'd20, 16'($urandom));
      send_packet(1'b1, 1'b1, next_seq + 8'd1, 10'd30, 16'($urandom));
      wait_idle();
   endtask

   initial begin
      strict_mode = 1'($urandom_range(1));
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_before_start();
      test_start_rule();
      test_window_edges();
      test_full_drain();
      test_back_pressure();
      test_random_traffic(100, 30, 30, 1'b1);
      test_random_traffic(90, 0, 0, 1'b0);
      test_random_traffic(90, 60, 50, 1'b1);
      test_session_end();
      if (mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/srrw_pkg.sv
sv/srrw_slot_ram.sv
sv/selective_repeat_receive_window_core.sv
sim/tb.sv
